FILE: src/hcbp_pkg.sv
// package with word types, command codes and table sizes for the huffman code bit packer
`default_nettype none

package hcbp_pkg;

    localparam int MAX_CODE_LEN  = 32;
    localparam int ALPHABET_SIZE = 256;
    localparam int CODE_WIDTH    = 32;
    localparam int TABLE_DEPTH   = 256;
    localparam int SYM_WIDTH     = 8;
    localparam int LEN_WIDTH     = 6;
    localparam int MAX_BYTES     = 4;

    // stored length is limited by both the parameter and the code field width
    localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_WIDTH) ? MAX_CODE_LEN : CODE_WIDTH;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    typedef struct packed {
        logic [1:0]            command;
        logic [SYM_WIDTH-1:0]  symbol;
        logic [CODE_WIDTH-1:0] code_bits;
        logic [LEN_WIDTH-1:0]  code_len;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_word_t;

endpackage

`default_nettype wire

FILE: src/huffman_code_bit_packer.sv
// huffman code bit packer: code table, bit accumulator and output byte queue
`default_nettype none

// Usage
// - in channel (in_valid / in_ready / in_data): one command word per handshake.
//   load writes a symbol's code and length into the table and gives no output,
//   encode packs the symbol's code msb first into the byte stream, flush sends
//   the pending partial byte left-aligned, then its valid-bit count.
// - out channel (out_valid / out_ready / out_data): one byte word per handshake,
//   last marks the final byte caused by one command word.
// - the table read is registered, so the first byte of an encode or flush
//   passes the read stage and then the byte queue before it shows.
// - one command word per cycle while each gives at most one byte and the
//   receiver takes every byte; a command giving n bytes (up to 4 for a 32-bit
//   code) holds the byte queue until all n have gone, one byte per cycle.
// - reset clears all table valid bits (every symbol reads with length zero and
//   encodes to nothing), the accumulator, the pending count and the byte queue.
// - when the receiver stalls, the byte queue holds; the stage behind it holds
//   only when it has bytes to add, so commands without output keep flowing.
module huffman_code_bit_packer (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  hcbp_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output hcbp_pkg::out_word_t out_data
);

    localparam int IDX_W  = $clog2(hcbp_pkg::TABLE_DEPTH);
    localparam int ENT_W  = hcbp_pkg::LEN_WIDTH + hcbp_pkg::CODE_WIDTH;
    localparam int WIDE_W = 8 + hcbp_pkg::CODE_WIDTH;
    localparam int QUE_W  = 8 * hcbp_pkg::MAX_BYTES;

    // code table: length and code per symbol, plus valid bits cleared at reset
    logic [ENT_W-1:0]                  table_mem [hcbp_pkg::TABLE_DEPTH];
    logic [hcbp_pkg::TABLE_DEPTH-1:0]  hit_reg;

    // table read stage
    logic                              s1_valid_reg;
    logic [1:0]                        s1_cmd_reg;
    logic                              s1_hit_reg;
    logic [ENT_W-1:0]                  s1_ent_reg;

    // accumulator, left-aligned with zeros below the pending bits
    logic [7:0]                        acc_reg, acc_next;
    logic [2:0]                        pend_reg, pend_next;

    // byte queue, first byte at the top
    logic [QUE_W-1:0]                  que_data_reg;
    logic [2:0]                        que_cnt_reg;

    logic                              in_accept;
    logic                              sym_ok;
    logic [hcbp_pkg::LEN_WIDTH-1:0]    load_len;
    logic [hcbp_pkg::LEN_WIDTH-1:0]    enc_len;
    logic [hcbp_pkg::CODE_WIDTH-1:0]   code_left;
    logic [WIDE_W-1:0]                 wide;
    logic [hcbp_pkg::LEN_WIDTH-1:0]    total;
    logic [2:0]                        res_cnt;
    logic [QUE_W-1:0]                  res_data;
    logic                              pop;
    logic                              que_free;
    logic                              s1_adv;

    assign in_accept = in_valid && in_ready;
    assign sym_ok    = ({1'b0, in_data.symbol} < 9'(hcbp_pkg::ALPHABET_SIZE));
    assign load_len  = (in_data.code_len > hcbp_pkg::LEN_WIDTH'(hcbp_pkg::LEN_LIMIT))
                     ? hcbp_pkg::LEN_WIDTH'(hcbp_pkg::LEN_LIMIT) : in_data.code_len;

    // table write on load, registered read on every accepted word
    always_ff @(posedge clk)
    begin
        if (in_accept && in_data.command == hcbp_pkg::CMD_LOAD && sym_ok)
        begin
            table_mem[in_data.symbol[IDX_W-1:0]] <= {load_len, in_data.code_bits};
        end
        if (in_accept)
        begin
            s1_ent_reg <= table_mem[in_data.symbol[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= '0;
        end
        else if (in_accept && in_data.command == hcbp_pkg::CMD_LOAD && sym_ok)
        begin
            hit_reg[in_data.symbol[IDX_W-1:0]] <= 1'b1;
        end
    end

    // read stage control; loads and unknown commands end here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_cmd_reg   <= hcbp_pkg::CMD_LOAD;
            s1_hit_reg   <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= (in_data.command == hcbp_pkg::CMD_ENCODE && sym_ok)
                         || in_data.command == hcbp_pkg::CMD_FLUSH;
            s1_cmd_reg   <= in_data.command;
            s1_hit_reg   <= hit_reg[in_data.symbol[IDX_W-1:0]];
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // packing: pending bits on top, code left-aligned right after them
    assign enc_len   = s1_hit_reg ? s1_ent_reg[ENT_W-1 -: hcbp_pkg::LEN_WIDTH]
                                  : '0;
    assign code_left = s1_ent_reg[hcbp_pkg::CODE_WIDTH-1:0]
                     << (hcbp_pkg::CODE_WIDTH - int'(enc_len));
    assign wide      = {acc_reg, {hcbp_pkg::CODE_WIDTH{1'b0}}}
                     | ({code_left, 8'b0} >> pend_reg);
    assign total     = hcbp_pkg::LEN_WIDTH'(pend_reg) + enc_len;

    always_comb
    begin
        res_cnt   = '0;
        res_data  = '0;
        acc_next  = acc_reg;
        pend_next = pend_reg;
        unique case (s1_cmd_reg)
            hcbp_pkg::CMD_ENCODE:
            begin
                res_cnt   = total[5:3];
                res_data  = wide[WIDE_W-1 -: QUE_W];
                pend_next = total[2:0];
                unique case (total[5:3])
                    3'd0:    acc_next = wide[39:32];
                    3'd1:    acc_next = wide[31:24];
                    3'd2:    acc_next = wide[23:16];
                    3'd3:    acc_next = wide[15:8];
                    3'd4:    acc_next = wide[7:0];
                    default: acc_next = '0;
                endcase
            end
            hcbp_pkg::CMD_FLUSH:
            begin
                if (pend_reg != 3'd0)
                begin
                    res_cnt   = 3'd2;
                    res_data  = {acc_reg, 5'b0, pend_reg, 16'b0};
                    acc_next  = '0;
                    pend_next = '0;
                end
            end
            default:
            begin
                res_cnt = '0;
            end
        endcase
    end

    // flow control between read stage and byte queue
    assign pop      = out_valid && out_ready;
    assign que_free = (que_cnt_reg == 3'd0) || (que_cnt_reg == 3'd1 && pop);
    assign s1_adv   = s1_valid_reg && (res_cnt == 3'd0 || que_free);
    assign in_ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            pend_reg <= '0;
        end
        else if (s1_adv)
        begin
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            que_cnt_reg <= '0;
        end
        else if (s1_adv && res_cnt != 3'd0)
        begin
            que_cnt_reg <= res_cnt;
        end
        else if (pop)
        begin
            que_cnt_reg <= que_cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && res_cnt != 3'd0)
        begin
            que_data_reg <= res_data;
        end
        else if (pop)
        begin
            que_data_reg <= {que_data_reg[QUE_W-9:0], 8'b0};
        end
    end

    assign out_valid         = (que_cnt_reg != 3'd0);
    assign out_data.out_byte = que_data_reg[QUE_W-1 -: 8];
    assign out_data.last     = (que_cnt_reg == 3'd1);

endmodule

`default_nettype wire

FILE: dv/huffman_code_bit_packer_tb.sv
// testbench for the huffman code bit packer: random and directed command words, scoreboard check
`default_nettype none

module huffman_code_bit_packer_tb;

    // the one command value the block must ignore
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // number of random command words after the directed part
    localparam int RANDOM_WORDS = 500;
    // receiver hold-off that fills the block and stalls its input
    localparam int LONG_HOLD_CYCLES = 300;
    // settle time after the last expected byte, well beyond the pipeline depth
    localparam int DRAIN_CYCLES = 20;

    // ------------------------------------------------------------------
    // scoreboard: own copy of the code table and accumulator, plus the
    // queue of bytes the block still owes
    // ------------------------------------------------------------------
    class packer_book;
        logic [hcbp_pkg::CODE_WIDTH-1:0] code_mem [hcbp_pkg::TABLE_DEPTH];
        logic [hcbp_pkg::LEN_WIDTH-1:0]  len_mem  [hcbp_pkg::TABLE_DEPTH];
        logic [7:0]                      acc;
        int unsigned                     held;
        hcbp_pkg::out_word_t             byte_q [$];
        int                              errors;

        function new();
            foreach (len_mem[i])
            begin
                len_mem[i]  = '0;
                code_mem[i] = '0;
            end
            acc    = '0;
            held   = 0;
            errors = 0;
        endfunction

        function void push_byte(logic [7:0] b);
            hcbp_pkg::out_word_t w;
            w.out_byte = b;
            w.last     = 1'b0;
            byte_q.push_back(w);
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
                $display("mismatch: %s", msg);
        endfunction

        // work out the bytes one accepted command word causes
        function void note_command(hcbp_pkg::in_word_t w);
            int unsigned len;
            int          first;
            int          i;
            first = byte_q.size();
            case (w.command)
                hcbp_pkg::CMD_LOAD:
                begin
                    if (w.symbol < hcbp_pkg::ALPHABET_SIZE)
                    begin
                        len = w.code_len;
                        if (len > hcbp_pkg::LEN_LIMIT)
                            len = hcbp_pkg::LEN_LIMIT;
                        code_mem[w.symbol] = w.code_bits;
                        len_mem[w.symbol]  = len[hcbp_pkg::LEN_WIDTH-1:0];
                    end
                end
                hcbp_pkg::CMD_ENCODE:
                begin
                    if (w.symbol < hcbp_pkg::ALPHABET_SIZE)
                    begin
                        // msb first into the accumulator, byte out when full
                        for (i = len_mem[w.symbol]; i > 0; i--)
                        begin
                            acc = {acc[6:0], code_mem[w.symbol][i-1]};
                            held++;
                            if (held == 8)
                            begin
                                push_byte(acc);
                                acc  = '0;
                                held = 0;
                            end
                        end
                    end
                end
                hcbp_pkg::CMD_FLUSH:
                begin
                    if (held != 0)
                    begin
                        push_byte(8'(acc << (8 - held)));
                        push_byte(8'(held));
                        acc  = '0;
                        held = 0;
                    end
                end
                default:
                begin
                end
            endcase
            if (byte_q.size() > first)
                byte_q[byte_q.size()-1].last = 1'b1;
        endfunction

        function void check_byte(hcbp_pkg::out_word_t got);
            hcbp_pkg::out_word_t want;
            if (byte_q.size() == 0)
            begin
                report($sformatf("unexpected byte %02h last %0b", got.out_byte, got.last));
                return;
            end
            want = byte_q.pop_front();
            if (got.out_byte !== want.out_byte || got.last !== want.last)
                report($sformatf("expected byte %02h last %0b, got byte %02h last %0b",
                                 want.out_byte, want.last, got.out_byte, got.last));
        endfunction

        function void close_out();
            if (byte_q.size() != 0)
                report($sformatf("%0d expected bytes never came out", byte_q.size()));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    hcbp_pkg::in_word_t  in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    hcbp_pkg::out_word_t out_data;

    // calm: no idling on either side; long_hold: one long receiver stall
    bit        calm      = 1'b0;
    bit        long_hold = 1'b0;

    packer_book book = new();

    // symbols loaded with a nonzero length, so encodes mostly hit real codes
    logic [hcbp_pkg::SYM_WIDTH-1:0] known_syms [$];

    huffman_code_bit_packer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // generous limit: worst case is far below this
    initial
    begin
        #2_000_000;
        $display("huffman_code_bit_packer_tb: FAIL");
        $finish;
    end

    // output side: every accepted byte word goes to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            book.check_byte(out_data);
    end

    // receiver: short random stalls, one long hold-off on request,
    // always ready once the run turns calm
    initial
    begin : receiver
        int n;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                // counted here, while the sender keeps offering words
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                long_hold = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 6);
                repeat (n) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic hcbp_pkg::in_word_t make_word(
        logic [1:0]                      cmd,
        logic [hcbp_pkg::SYM_WIDTH-1:0]  sym,
        logic [hcbp_pkg::CODE_WIDTH-1:0] bits,
        logic [hcbp_pkg::LEN_WIDTH-1:0]  len
    );
        hcbp_pkg::in_word_t w;
        w.command   = cmd;
        w.symbol    = sym;
        w.code_bits = bits;
        w.code_len  = len;
        return w;
    endfunction

    // random command word: mostly encodes of loaded symbols, with loads,
    // flushes and some noise in between
    function automatic hcbp_pkg::in_word_t random_word();
        int                             pick;
        logic [hcbp_pkg::LEN_WIDTH-1:0] len;
        logic [hcbp_pkg::SYM_WIDTH-1:0] sym;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            case ($urandom_range(0, 9))
                0:       len = hcbp_pkg::LEN_WIDTH'($urandom_range(33, 63)); // clamped to 32
                1:       len = '0;                                 // disables the symbol
                2, 3:    len = hcbp_pkg::LEN_WIDTH'($urandom_range(13, 32));
                default: len = hcbp_pkg::LEN_WIDTH'($urandom_range(1, 12));
            endcase
            return make_word(hcbp_pkg::CMD_LOAD,
                             hcbp_pkg::SYM_WIDTH'($urandom_range(0, 255)), $urandom, len);
        end
        else if (pick < 82)
        begin
            if (known_syms.size() != 0 && $urandom_range(0, 9) != 0)
                sym = known_syms[$urandom_range(0, known_syms.size() - 1)];
            else
                sym = hcbp_pkg::SYM_WIDTH'($urandom_range(0, 255));
            return make_word(hcbp_pkg::CMD_ENCODE, sym, $urandom,
                             hcbp_pkg::LEN_WIDTH'($urandom_range(0, 63)));
        end
        else if (pick < 97)
        begin
            return make_word(hcbp_pkg::CMD_FLUSH,
                             hcbp_pkg::SYM_WIDTH'($urandom_range(0, 255)), $urandom,
                             hcbp_pkg::LEN_WIDTH'($urandom_range(0, 63)));
        end
        return make_word(CMD_UNUSED, hcbp_pkg::SYM_WIDTH'($urandom_range(0, 255)), $urandom,
                         hcbp_pkg::LEN_WIDTH'($urandom_range(0, 63)));
    endfunction

    // offer one command word, called at a falling edge, returns at a falling edge
    task automatic send_word(hcbp_pkg::in_word_t w);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        book.note_command(w);
        if (w.command == hcbp_pkg::CMD_LOAD && w.code_len != 0)
            known_syms.push_back(w.symbol);
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        int n;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part
        // symbol never loaded: encodes to nothing
        send_word(make_word(hcbp_pkg::CMD_ENCODE, 8'd5, 32'h0, 6'd0));
        // flush with nothing pending
        send_word(make_word(hcbp_pkg::CMD_FLUSH, 8'd0, 32'h0, 6'd0));
        // unused command with every field bit high: ignored
        send_word(make_word(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F));
        // full-length code of all ones, shortest code on the top symbol
        send_word(make_word(hcbp_pkg::CMD_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd32));
        send_word(make_word(hcbp_pkg::CMD_LOAD, 8'd255, 32'h0000_0001, 6'd1));
        // longest length field, clamped to the code width
        send_word(make_word(hcbp_pkg::CMD_LOAD, 8'd1, 32'hA5A5_A5A5, 6'h3F));
        // zero length disables the symbol
        send_word(make_word(hcbp_pkg::CMD_LOAD, 8'd2, 32'h0000_0000, 6'd0));
        send_word(make_word(hcbp_pkg::CMD_LOAD, 8'd3, 32'h0000_0005, 6'd3));
        send_word(make_word(hcbp_pkg::CMD_LOAD, 8'd4, 32'h5555_5555, 6'd33));
        // one bit pending, then 32-bit codes that give four bytes each
        send_word(make_word(hcbp_pkg::CMD_ENCODE, 8'd255, 32'h0, 6'd0));
        send_word(make_word(hcbp_pkg::CMD_ENCODE, 8'd0, 32'h0, 6'd0));
        send_word(make_word(hcbp_pkg::CMD_ENCODE, 8'd1, 32'h0, 6'd0));
        send_word(make_word(hcbp_pkg::CMD_ENCODE, 8'd2, 32'h0, 6'd0));
        send_word(make_word(hcbp_pkg::CMD_ENCODE, 8'd3, 32'h0, 6'd0));
        // partial byte, left-aligned, then its bit count
        send_word(make_word(hcbp_pkg::CMD_FLUSH, 8'd0, 32'h0, 6'd0));
        // byte boundary hit exactly, so the flush right after gives nothing
        send_word(make_word(hcbp_pkg::CMD_ENCODE, 8'd4, 32'h0, 6'd0));
        send_word(make_word(hcbp_pkg::CMD_FLUSH, 8'd0, 32'h0, 6'd0));
        // seven pending bits, then a flush
        send_word(make_word(hcbp_pkg::CMD_ENCODE, 8'd3, 32'h0, 6'd0));
        send_word(make_word(hcbp_pkg::CMD_ENCODE, 8'd3, 32'h0, 6'd0));
        send_word(make_word(hcbp_pkg::CMD_ENCODE, 8'd255, 32'h0, 6'd0));
        send_word(make_word(hcbp_pkg::CMD_FLUSH, 8'd0, 32'h0, 6'd0));
        // reload an entry with a shorter code
        send_word(make_word(hcbp_pkg::CMD_LOAD, 8'd0, 32'hFFFF_FFFE, 6'd2));
        send_word(make_word(hcbp_pkg::CMD_ENCODE, 8'd0, 32'h0, 6'd0));
        send_word(make_word(hcbp_pkg::CMD_FLUSH, 8'd0, 32'h0, 6'd0));

        // random part
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            // block backs up while the receiver holds off
            if (n == 150)
                long_hold = 1'b1;
            // last stretch runs at full rate on both sides
            if (n == 420)
                calm = 1'b1;
            send_word(random_word());
        end
        // close out any pending bits
        send_word(make_word(hcbp_pkg::CMD_FLUSH, 8'd0, 32'h0, 6'd0));
        in_valid <= 1'b0;

        // drain, then a short settle to catch stray bytes
        while (book.byte_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        book.close_out();

        if (book.errors == 0)
            $display("huffman_code_bit_packer_tb: PASS");
        else
            $display("huffman_code_bit_packer_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
